// File: sv/ppt_pkg.sv
`timescale 1ns / 1ps

package ppt_pkg;

  // coordinate and arithmetic widths
  localparam int COORD_W  = 24;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int MAG_W    = 2 * COORD_W + 1;
  localparam int OP_W     = MAG_W + 1;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int SPROD_W  = PROD_W + 1;
  localparam int DIGIT_W  = 2;
  localparam int TOL_W    = 8;
  localparam int TOL_SQ_W = 2 * TOL_W;
  localparam int CNT_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam int TOL_RESET = 3;
  localparam logic [TOL_SQ_W-1:0] TOL_SQ_RESET = TOL_SQ_W'(TOL_RESET * TOL_RESET);
  localparam logic [CNT_W-1:0] MIN_VERTS = CNT_W'(3);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INCLUDE_EDGE = 1'b0,
    REG_EDGE_TOL     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } vtx_word_t;

  typedef struct packed {
    logic inside_res;
    logic on_edge;
    logic too_few_vertices;
  } res_word_t;

  // edge test request and response
  typedef struct packed {
    logic                      start;
    logic                      incl_edge;
    logic [TOL_SQ_W-1:0]       tol_sq;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
  } edge_req_t;

  typedef struct packed {
    logic done;
    logic toggle;
    logic hit;
  } edge_rsp_t;

  // multiplier request and response
  typedef struct packed {
    logic                   start;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SPROD_W-1:0] prod;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_PREP,
    MUL_RUN,
    MUL_FIN
  } mul_state_t;

  typedef enum logic [3:0] {
    E_IDLE,
    E_LEN_X,
    E_LEN_Y,
    E_PT_X,
    E_PT_Y,
    E_DOT_X,
    E_DOT_Y,
    E_CR_A,
    E_CR_B,
    E_CSQ,
    E_TOL,
    E_DONE
  } edge_state_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_EDGE1,
    T_EDGE2,
    T_EMIT
  } top_state_t;

endpackage

// File: sv/ppt_mul.sv
`timescale 1ns / 1ps

module ppt_mul (
  input  logic              clk,
  input  logic              rst,
  input  ppt_pkg::mul_req_t req,
  output ppt_pkg::mul_rsp_t rsp
);
  import ppt_pkg::*;

  mul_state_t state, state_next;

  logic [PROD_W-1:0]  mcand;
  logic [PROD_W-1:0]  mcand3;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  part;
  logic [MAG_W-1:0]   mplier;
  logic [MAG_W-1:0]   a_mag;
  logic [MAG_W-1:0]   b_mag;
  logic [SPROD_W-1:0] acc_ext;
  logic               neg;
  logic               done;
  logic [SPROD_W-1:0] prod;

  // operand magnitudes
  assign a_mag = req.a[OP_W-1] ? MAG_W'(~req.a + 1'b1) : MAG_W'(req.a);
  assign b_mag = req.b[OP_W-1] ? MAG_W'(~req.b + 1'b1) : MAG_W'(req.b);
  assign acc_ext = {1'b0, acc};

  // radix-4 partial product from the low digit of the multiplier
  always_comb begin
    case (mplier[DIGIT_W-1:0])
      DIGIT_W'(0): part = '0;
      DIGIT_W'(1): part = mcand;
      DIGIT_W'(2): part = mcand << 1;
      DIGIT_W'(3): part = mcand3;
      default:     part = '0;
    endcase
  end

  // sequencing: load, triple the multiplicand, one digit per cycle, sign fix
  always_comb begin
    state_next = state;
    case (state)
      MUL_IDLE: begin
        if (req.start) state_next = MUL_PREP;
      end
      MUL_PREP: state_next = MUL_RUN;
      MUL_RUN: begin
        if (mplier == '0) state_next = MUL_FIN;
      end
      MUL_FIN: state_next = MUL_IDLE;
      default: state_next = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == MUL_FIN);
    end
  end

  // shift-add datapath
  always_ff @(posedge clk) begin
    case (state)
      MUL_IDLE: begin
        if (req.start) begin
          mcand  <= PROD_W'(a_mag);
          mplier <= b_mag;
          neg    <= req.a[OP_W-1] ^ req.b[OP_W-1];
          acc    <= '0;
        end
      end
      MUL_PREP: mcand3 <= mcand + (mcand << 1);
      MUL_RUN: begin
        if (mplier != '0) begin
          acc    <= acc + part;
          mcand  <= mcand << DIGIT_W;
          mcand3 <= mcand3 << DIGIT_W;
          mplier <= mplier >> DIGIT_W;
        end
      end
      MUL_FIN: prod <= neg ? (~acc_ext + 1'b1) : acc_ext;
      default: ;
    endcase
  end

  always_comb begin
    rsp.done = done;
    rsp.prod = prod;
  end

endmodule

// File: sv/ppt_edge.sv
`timescale 1ns / 1ps

module ppt_edge (
  input  logic               clk,
  input  logic               rst,
  input  ppt_pkg::edge_req_t req,
  output ppt_pkg::edge_rsp_t rsp
);
  import ppt_pkg::*;

  edge_state_t state, state_next;
  logic        issued, issued_next;
  logic        mul_state;

  mul_req_t mreq;
  mul_rsp_t mrsp;

  logic signed [DIFF_W-1:0]  dx, dy, wx, wy;
  logic                      straddle, dx_pos, incl, want_near;
  logic [TOL_SQ_W-1:0]       tol_sq;
  logic signed [SPROD_W-1:0] sum;
  logic signed [OP_W-1:0]    len2;
  logic signed [OP_W-1:0]    cross_val;
  logic                      hit, toggle;

  logic                      strad_in;
  logic signed [SPROD_W-1:0] sum_add, diff_sub, len2_w, tol_w;
  logic                      dot_ok, cross_pos, cross_neg, toggle_v;
  logic signed [OP_W-1:0]    op_a, op_b;

  ppt_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  // half-open x straddle of the new edge
  assign strad_in = ((req.ax < req.tx) && (req.bx >= req.tx)) ||
                    ((req.bx < req.tx) && (req.ax >= req.tx));

  // running sums and compares on the returned product
  assign sum_add   = sum + mrsp.prod;
  assign diff_sub  = mrsp.prod - sum;
  assign len2_w    = SPROD_W'(len2);
  assign tol_w     = SPROD_W'(tol_sq);
  assign dot_ok    = !sum_add[SPROD_W-1] && (sum_add <= len2_w);
  assign cross_pos = !diff_sub[SPROD_W-1] && (diff_sub != '0);
  assign cross_neg = diff_sub[SPROD_W-1];
  assign toggle_v  = straddle && (dx_pos ? cross_pos : cross_neg);

  assign mul_state = state inside {E_LEN_X, E_LEN_Y, E_PT_X, E_PT_Y, E_DOT_X,
                                   E_DOT_Y, E_CR_A, E_CR_B, E_CSQ, E_TOL};

  // operand select per step
  always_comb begin
    op_a = OP_W'(dx);
    op_b = OP_W'(dx);
    case (state)
      E_LEN_X: begin op_a = OP_W'(dx); op_b = OP_W'(dx); end
      E_LEN_Y: begin op_a = OP_W'(dy); op_b = OP_W'(dy); end
      E_PT_X:  begin op_a = OP_W'(wx); op_b = OP_W'(wx); end
      E_PT_Y:  begin op_a = OP_W'(wy); op_b = OP_W'(wy); end
      E_DOT_X: begin op_a = OP_W'(dx); op_b = OP_W'(wx); end
      E_DOT_Y: begin op_a = OP_W'(dy); op_b = OP_W'(wy); end
      E_CR_A:  begin op_a = OP_W'(wx); op_b = OP_W'(dy); end
      E_CR_B:  begin op_a = OP_W'(wy); op_b = OP_W'(dx); end
      E_CSQ:   begin op_a = cross_val; op_b = cross_val; end
      E_TOL:   begin op_a = len2;      op_b = OP_W'(tol_sq); end
      default: ;
    endcase
  end

  // step sequencer
  always_comb begin
    state_next  = state;
    mreq.start  = mul_state && !issued;
    mreq.a      = op_a;
    mreq.b      = op_b;
    issued_next = mul_state && !mrsp.done && (issued || mreq.start);
    case (state)
      E_IDLE: begin
        if (req.start) begin
          if (req.incl_edge) state_next = E_LEN_X;
          else if (strad_in) state_next = E_CR_A;
          else               state_next = E_DONE;
        end
      end
      E_LEN_X: if (mrsp.done) state_next = E_LEN_Y;
      E_LEN_Y: if (mrsp.done) state_next = (sum_add == '0) ? E_PT_X : E_DOT_X;
      E_PT_X:  if (mrsp.done) state_next = E_PT_Y;
      E_PT_Y:  if (mrsp.done) state_next = E_DONE;
      E_DOT_X: if (mrsp.done) state_next = E_DOT_Y;
      E_DOT_Y: if (mrsp.done) state_next = (dot_ok || straddle) ? E_CR_A : E_DONE;
      E_CR_A:  if (mrsp.done) state_next = E_CR_B;
      E_CR_B:  if (mrsp.done) state_next = want_near ? E_CSQ : E_DONE;
      E_CSQ:   if (mrsp.done) state_next = E_TOL;
      E_TOL:   if (mrsp.done) state_next = E_DONE;
      E_DONE:  state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= E_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  // edge setup and per-step results
  always_ff @(posedge clk) begin
    if (state == E_IDLE && req.start) begin
      dx        <= DIFF_W'(req.bx) - DIFF_W'(req.ax);
      dy        <= DIFF_W'(req.by) - DIFF_W'(req.ay);
      wx        <= DIFF_W'(req.tx) - DIFF_W'(req.ax);
      wy        <= DIFF_W'(req.ty) - DIFF_W'(req.ay);
      straddle  <= strad_in;
      dx_pos    <= req.bx > req.ax;
      incl      <= req.incl_edge;
      tol_sq    <= req.tol_sq;
      want_near <= 1'b0;
      hit       <= 1'b0;
      toggle    <= 1'b0;
    end
    if (mrsp.done) begin
      case (state)
        E_LEN_X: sum <= mrsp.prod;
        E_LEN_Y: len2 <= sum_add[OP_W-1:0];
        E_PT_X:  sum <= mrsp.prod;
        E_PT_Y:  hit <= incl && (sum_add <= tol_w);
        E_DOT_X: sum <= mrsp.prod;
        E_DOT_Y: want_near <= dot_ok;
        E_CR_A:  sum <= mrsp.prod;
        E_CR_B: begin
          cross_val <= diff_sub[OP_W-1:0];
          toggle    <= toggle_v;
        end
        E_CSQ:   sum <= mrsp.prod;
        E_TOL:   hit <= incl && (sum <= mrsp.prod);
        default: ;
      endcase
    end
  end

  always_comb begin
    rsp.done   = (state == E_DONE);
    rsp.toggle = toggle;
    rsp.hit    = hit;
  end

endmodule

// File: sv/point_in_polygon_test_unit.sv
`timescale 1ns / 1ps

// even-odd point-in-polygon test over a stream of vertices
// vtx channel: one word per vertex; the test point is taken from the first word
// of each polygon, last_vertex closes the polygon; vtx_stall is high while a
// vertex is being worked on, so one vertex is in flight at a time
// res channel: one word per polygon, given after the word marked last_vertex;
// a polygon of fewer than three vertices reports too_few_vertices
// cfg channel: include_edge (index 0), edge_tolerance (index 1); the user must
// write them with no polygon in flight, unenforced; cfg_ready is high while idle
// every edge runs through one shared radix-4 shift-add multiplier; a multiply
// step lasts longer on a larger second operand, such as the squared cross term
// the first vertex of a polygon tests no edge; every other vertex tests its
// new edge: with no x straddle and include_edge low the multiplier is idle, a
// straddle adds the cross-product steps and include_edge high the length,
// dot and tolerance steps; the last vertex of a polygon of three or more
// vertices also tests the closing edge; the emit step loads the result register
// the result register holds its word while res_stall is high; the next vertex
// is still taken, and only a new result waits for the register to free up
// reset clears the polygon, include_edge to 0 and edge_tolerance to 3
module point_in_polygon_test_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vtx_valid,
  output logic                             vtx_stall,
  input  ppt_pkg::vtx_word_t               vtx_word,
  output logic                             res_valid,
  input  logic                             res_stall,
  output ppt_pkg::res_word_t               res_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ppt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppt_pkg::TOL_W-1:0]        cfg_data
);
  import ppt_pkg::*;

  top_state_t state, state_next;

  logic                      include_edge;
  logic [TOL_SQ_W-1:0]       tol_sq;
  logic signed [COORD_W-1:0] test_x, test_y;
  logic signed [COORD_W-1:0] first_vx, first_vy;
  logic signed [COORD_W-1:0] prev_vx, prev_vy;
  logic signed [COORD_W-1:0] cur_vx, cur_vy;
  logic                      crossing_parity, edge_hit, last_flag;
  logic [CNT_W-1:0]          vertex_count;
  logic                      launch, launch_next;

  logic      vtx_acc, res_free, few;
  res_word_t res_calc;
  edge_req_t ereq;
  edge_rsp_t ersp;

  ppt_edge u_edge (
    .clk (clk),
    .rst (rst),
    .req (ereq),
    .rsp (ersp)
  );

  assign vtx_stall = (state != T_IDLE);
  assign cfg_ready = (state == T_IDLE);
  assign vtx_acc   = vtx_valid && !vtx_stall;
  assign res_free  = !res_valid || !res_stall;

  // edge operands: new edge first, closing edge on the last vertex
  always_comb begin
    ereq.start     = launch;
    ereq.incl_edge = include_edge;
    ereq.tol_sq    = tol_sq;
    ereq.tx        = test_x;
    ereq.ty        = test_y;
    if (state == T_EDGE2) begin
      ereq.ax = first_vx;
      ereq.ay = first_vy;
      ereq.bx = cur_vx;
      ereq.by = cur_vy;
    end else begin
      ereq.ax = cur_vx;
      ereq.ay = cur_vy;
      ereq.bx = prev_vx;
      ereq.by = prev_vy;
    end
  end

  // result word
  always_comb begin
    few                       = vertex_count < MIN_VERTS;
    res_calc.too_few_vertices = few;
    res_calc.on_edge          = !few && edge_hit;
    res_calc.inside_res       = !few && (edge_hit || crossing_parity);
  end

  // polygon sequencing
  always_comb begin
    state_next  = state;
    launch_next = 1'b0;
    case (state)
      T_IDLE: begin
        if (vtx_acc) begin
          if (vertex_count == '0) begin
            state_next = vtx_word.last_vertex ? T_EMIT : T_IDLE;
          end else begin
            state_next  = T_EDGE1;
            launch_next = 1'b1;
          end
        end
      end
      T_EDGE1: begin
        if (ersp.done) begin
          if (last_flag && vertex_count == MIN_VERTS) begin
            state_next  = T_EDGE2;
            launch_next = 1'b1;
          end else if (last_flag) begin
            state_next = T_EMIT;
          end else begin
            state_next = T_IDLE;
          end
        end
      end
      T_EDGE2: begin
        if (ersp.done) state_next = T_EMIT;
      end
      T_EMIT: begin
        if (res_free) state_next = T_IDLE;
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= launch_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      include_edge <= 1'b0;
      tol_sq       <= TOL_SQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INCLUDE_EDGE: include_edge <= cfg_data[0];
        REG_EDGE_TOL:     tol_sq <= TOL_SQ_W'(cfg_data) * TOL_SQ_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // polygon control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count    <= '0;
      crossing_parity <= 1'b0;
      edge_hit        <= 1'b0;
      last_flag       <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (vtx_acc) begin
        last_flag <= vtx_word.last_vertex;
        if (vertex_count != MIN_VERTS) vertex_count <= vertex_count + 1'b1;
      end
      if (ersp.done) begin
        crossing_parity <= crossing_parity ^ ersp.toggle;
        edge_hit        <= edge_hit | ersp.hit;
      end
      if (state == T_EMIT && res_free) begin
        res_valid       <= 1'b1;
        vertex_count    <= '0;
        crossing_parity <= 1'b0;
        edge_hit        <= 1'b0;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // vertex coordinates and result word
  always_ff @(posedge clk) begin
    if (vtx_acc) begin
      if (vertex_count == '0) begin
        test_x   <= vtx_word.point_x;
        test_y   <= vtx_word.point_y;
        first_vx <= vtx_word.vertex_x;
        first_vy <= vtx_word.vertex_y;
        prev_vx  <= vtx_word.vertex_x;
        prev_vy  <= vtx_word.vertex_y;
      end
      cur_vx <= vtx_word.vertex_x;
      cur_vy <= vtx_word.vertex_y;
    end
    if (state == T_EDGE1 && ersp.done) begin
      prev_vx <= cur_vx;
      prev_vy <= cur_vy;
    end
    if (state == T_EMIT && res_free) res_word <= res_calc;
  end

  // edge unit reports only while an edge is in flight
  a_edge_done: assert property (@(posedge clk) disable iff (rst)
    ersp.done |-> (state == T_EDGE1 || state == T_EDGE2))
    else $error("edge result outside an edge step");

  // a short polygon never reports inside or on edge
  a_few: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.too_few_vertices) |->
      (!res_word.inside_res && !res_word.on_edge))
    else $error("short polygon reported inside");

  // on edge always implies inside
  a_on_edge: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.on_edge) |-> res_word.inside_res)
    else $error("on edge without inside");

  // a new result word comes only from the emit step
  a_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == T_EMIT))
    else $error("result word without emit step");

endmodule

// File: bench/point_in_polygon_test_unit_test.sv
`timescale 1ns / 1ps

module point_in_polygon_test_unit_test;
  import ppt_pkg::*;

  localparam longint CMIN = -8388608;
  localparam longint CMAX = 8388607;
  localparam int SETTLE_CYCLES = 400;
  localparam int STUCK_LIMIT = 5000;
  localparam int PHASES = 8;
  localparam int PHASE_VERTICES = 240;

  typedef enum int {SHAPE_TIGHT, SHAPE_WIDE, SHAPE_CORNER} shape_t;

  // even-odd predictor with its own polygon state and register mirror
  class polygon_checker;
    bit          include_edge;
    bit [7:0]    edge_tol;
    longint      test_x, test_y, first_x, first_y, prev_x, prev_y;
    bit          parity, hit;
    int unsigned nverts;
    res_word_t   verdicts_due[$];
    int unsigned errors, n_verdicts, n_inside, n_edge, n_few;

    function new();
      include_edge = 1'b0;
      edge_tol = 8'(TOL_RESET);
      clear_polygon();
    endfunction

    function void clear_polygon();
      test_x = 0; test_y = 0; first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      parity = 1'b0;
      hit = 1'b0;
      nverts = 0;
    endfunction

    // point within tolerance of segment a-b, exact wide compare
    function bit edge_near(longint ax, longint ay, longint bx, longint by);
      longint dx, dy, wx, wy, len2, dot, crs;
      longint unsigned tol2;
      bit [127:0] cm, lm, tm;
      dx = bx - ax;
      dy = by - ay;
      wx = test_x - ax;
      wy = test_y - ay;
      len2 = dx * dx + dy * dy;
      tol2 = edge_tol * edge_tol;
      if (len2 == 0) return (wx * wx + wy * wy) <= tol2;
      dot = dx * wx + dy * wy;
      if (dot < 0 || dot > len2) return 1'b0;
      crs = dx * wy - dy * wx;
      if (crs < 0) crs = -crs;
      cm = crs;
      lm = len2;
      tm = tol2;
      return (cm * cm) <= (tm * lm);
    endfunction

    // half-open crossing test plus optional on-edge test
    function void edge_step(longint x1, longint y1, longint x2, longint y2);
      longint lhs, rhs;
      bit below;
      if (include_edge && edge_near(x1, y1, x2, y2)) hit = 1'b1;
      if ((x1 < test_x && x2 >= test_x) || (x2 < test_x && x1 >= test_x)) begin
        lhs = (test_x - x1) * (y2 - y1);
        rhs = (test_y - y1) * (x2 - x1);
        below = (x2 > x1) ? (lhs < rhs) : (lhs > rhs);
        if (below) parity = ~parity;
      end
    endfunction

    function void take_vertex(vtx_word_t w);
      longint vx, vy;
      bit few;
      res_word_t verdict;
      vx = $signed(w.vertex_x);
      vy = $signed(w.vertex_y);
      if (nverts == 0) begin
        test_x = $signed(w.point_x);
        test_y = $signed(w.point_y);
        first_x = vx;
        first_y = vy;
      end else begin
        edge_step(vx, vy, prev_x, prev_y);
      end
      prev_x = vx;
      prev_y = vy;
      if (nverts < 3) nverts++;
      if (!w.last_vertex) return;
      few = (nverts < 3);
      if (!few) edge_step(first_x, first_y, vx, vy);
      verdict.inside_res = few ? 1'b0 : (hit ? 1'b1 : parity);
      verdict.on_edge = few ? 1'b0 : hit;
      verdict.too_few_vertices = few;
      verdicts_due.push_back(verdict);
      clear_polygon();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_verdict(res_word_t got);
      res_word_t want;
      if (verdicts_due.size() == 0) begin
        report("result word with no polygon outstanding");
      end else begin
        want = verdicts_due.pop_front();
        if (got.inside_res !== want.inside_res)
          report($sformatf("verdict %0d inside_res got %b want %b",
                           n_verdicts, got.inside_res, want.inside_res));
        if (got.on_edge !== want.on_edge)
          report($sformatf("verdict %0d on_edge got %b want %b",
                           n_verdicts, got.on_edge, want.on_edge));
        if (got.too_few_vertices !== want.too_few_vertices)
          report($sformatf("verdict %0d too_few_vertices got %b want %b",
                           n_verdicts, got.too_few_vertices, want.too_few_vertices));
        n_inside += want.inside_res;
        n_edge += want.on_edge;
        n_few += want.too_few_vertices;
      end
      n_verdicts++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic vtx_valid = 1'b0;
  logic vtx_stall;
  vtx_word_t vtx_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_word_t res_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_INCLUDE_EDGE;
  logic [TOL_W-1:0] cfg_data = '0;

  polygon_checker chk = new();
  longint poly_x[$], poly_y[$];
  int unsigned n_vertices = 0;
  int unsigned n_settings = 1;
  int stuck_cycles = 0;
  int stall_left = 0;

  point_in_polygon_test_unit u_top (
    .clk(clk),
    .rst(rst),
    .vtx_valid(vtx_valid),
    .vtx_stall(vtx_stall),
    .vtx_word(vtx_word),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_word(res_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // result word monitor
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) chk.check_verdict(res_word);
  end

  // progress watchdog
  always @(posedge clk) begin
    if (!rst && ((vtx_valid && !vtx_stall) || (res_valid && !res_stall) ||
                 (cfg_valid && cfg_ready)))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles", STUCK_LIMIT);
    $display("FAIL");
    $finish;
  end

  // receiver stall runs: mostly short, a few long, some long quiet stretches
  always @(negedge clk) begin
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        res_stall <= 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (r < 85) begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (r < 95) begin
        res_stall <= 1'b0;
        stall_left = $urandom_range(20, 80);
      end else begin
        res_stall <= 1'b1;
        stall_left = $urandom_range(20, 60);
      end
    end
    stall_left--;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint fit_coord(longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic longint rand_coord(shape_t shape, longint span);
    case (shape)
      SHAPE_TIGHT: return longint'($urandom_range(0, 2 * span)) - span;
      SHAPE_WIDE: return longint'($signed(24'($urandom)));
      default: begin
        case ($urandom_range(0, 4))
          0: return CMIN;
          1: return CMAX;
          2: return 0;
          3: return -1;
          default: return longint'($signed(24'($urandom)));
        endcase
      end
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_vertex(input vtx_word_t w, input int gap);
    if (gap > 0) begin
      vtx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx_valid <= 1'b1;
    vtx_word <= w;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    chk.take_vertex(w);
    n_vertices++;
    @(negedge clk);
  endtask

  // send poly_x/poly_y as one polygon around test point (px, py)
  task automatic send_poly(input longint px, input longint py, input bit quiet);
    vtx_word_t w;
    int k;
    for (k = 0; k < poly_x.size(); k++) begin
      w.point_x = (k == 0) ? COORD_W'(px) : COORD_W'($urandom);
      w.point_y = (k == 0) ? COORD_W'(py) : COORD_W'($urandom);
      w.vertex_x = COORD_W'(poly_x[k]);
      w.vertex_y = COORD_W'(poly_y[k]);
      w.last_vertex = (k == poly_x.size() - 1);
      send_vertex(w, quiet ? 0 : pick_gap());
    end
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [TOL_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_INCLUDE_EDGE) chk.include_edge = val[0];
    else chk.edge_tol = val;
  endtask

  task automatic set_config(input bit inc, input logic [TOL_W-1:0] tol);
    write_reg(REG_INCLUDE_EDGE, TOL_W'(inc));
    @(negedge clk);
    write_reg(REG_EDGE_TOL, tol);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // wait out every verdict, then the worst-case vertex latency
  task automatic settle();
    vtx_valid <= 1'b0;
    while (chk.verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_polygon();
    shape_t shape;
    longint span, px, py, ax, ay, bx, by;
    int nv, r, k, j;
    r = $urandom_range(0, 99);
    shape = (r < 65) ? SHAPE_TIGHT : (r < 85) ? SHAPE_WIDE : SHAPE_CORNER;
    span = longint'(1) << $urandom_range(3, 14);
    r = $urandom_range(0, 99);
    nv = (r < 4) ? 1 : (r < 10) ? 2 : (r < 85) ? $urandom_range(3, 6) : $urandom_range(7, 12);
    poly_x.delete();
    poly_y.delete();
    // vertices, with repeated points and axis-aligned edges mixed in
    for (k = 0; k < nv; k++) begin
      r = $urandom_range(0, 99);
      if (k > 0 && r < 8) begin
        poly_x.push_back(poly_x[k-1]);
        poly_y.push_back(poly_y[k-1]);
      end else if (k > 0 && r < 14) begin
        poly_x.push_back(poly_x[k-1]);
        poly_y.push_back(rand_coord(shape, span));
      end else if (k > 0 && r < 20) begin
        poly_x.push_back(rand_coord(shape, span));
        poly_y.push_back(poly_y[k-1]);
      end else begin
        poly_x.push_back(rand_coord(shape, span));
        poly_y.push_back(rand_coord(shape, span));
      end
    end
    // test point: free, on a vertex, on or near an edge, or at the extremes
    k = $urandom_range(0, nv - 1);
    ax = poly_x[k];
    ay = poly_y[k];
    bx = poly_x[(k + 1) % nv];
    by = poly_y[(k + 1) % nv];
    r = $urandom_range(0, 99);
    if (r < 30) begin
      px = rand_coord(shape, span);
      py = rand_coord(shape, span);
    end else if (r < 42) begin
      px = ax;
      py = ay;
    end else if (r < 70) begin
      j = $urandom_range(0, 8);
      px = ax + (bx - ax) * j / 8;
      py = ay + (by - ay) * j / 8;
    end else if (r < 90) begin
      px = fit_coord(ax + (bx - ax) / 2 + longint'($urandom_range(0, 600)) - 300);
      py = fit_coord(ay + (by - ay) / 2 + longint'($urandom_range(0, 600)) - 300);
    end else begin
      px = rand_coord(SHAPE_CORNER, span);
      py = rand_coord(SHAPE_CORNER, span);
    end
    send_poly(px, py, $urandom_range(0, 99) < 20);
  endtask

  initial begin
    bit inc_set[PHASES];
    int tol_set[PHASES];
    int ph;
    int unsigned start_count;
    inc_set = '{1, 1, 0, 1, 0, 1, 1, 0};
    tol_set = '{0, 255, 255, 3, 0, 0, 0, 0};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, edge inclusion off
    poly_x = '{0, 2560, 0};
    poly_y = '{0, 0, 2560};
    send_poly(256, 256, 1'b0);
    send_poly(-256, 256, 1'b0);
    send_poly(1280, 0, 1'b0);
    poly_x = '{CMAX};
    poly_y = '{CMIN};
    send_poly(CMIN, CMAX, 1'b0);
    poly_x = '{CMIN, CMAX};
    poly_y = '{CMIN, CMAX};
    send_poly(0, 0, 1'b0);
    poly_x = '{CMIN, CMAX, CMIN};
    poly_y = '{CMIN, CMIN, CMAX};
    send_poly(-1, -1, 1'b0);
    settle();

    // directed: edge inclusion on, near edge, zero-length edge, short polygon
    set_config(1'b1, 8'd3);
    poly_x = '{0, 2560, 0};
    poly_y = '{0, 0, 2560};
    send_poly(1280, 2, 1'b0);
    poly_x = '{0, 0, 2560, 0};
    poly_y = '{0, 0, 0, 2560};
    send_poly(1, 1, 1'b0);
    poly_x = '{0, 2560};
    poly_y = '{0, 0};
    send_poly(1280, 0, 1'b0);

    // random phases over several register settings
    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph >= 5) begin
        inc_set[ph] = $urandom_range(0, 1);
        tol_set[ph] = $urandom_range(1, 254);
      end
      set_config(inc_set[ph], TOL_W'(tol_set[ph]));
      start_count = n_vertices;
      while (n_vertices - start_count < PHASE_VERTICES) random_polygon();
    end
    settle();

    if (chk.verdicts_due.size() != 0)
      chk.report($sformatf("%0d verdicts never arrived", chk.verdicts_due.size()));
    $display("checked %0d polygon verdicts from %0d vertices under %0d register settings",
             chk.n_verdicts, n_vertices, n_settings);
    $display("verdicts seen: %0d inside, %0d on an edge, %0d with too few vertices",
             chk.n_inside, chk.n_edge, chk.n_few);
    if (chk.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
